// ===== src/tbd_pkg.sv =====
package tbd_pkg;

  localparam int COUNT_W   = 12;
  localparam int UNION_W   = COUNT_W + 1;
  localparam int REM_W     = UNION_W + 1;
  localparam int POP_W     = 6;
  localparam int DIST_W    = 17;
  localparam int DIV_STEPS = DIST_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int WORD_W    = 32;
  localparam int IN_DATA_W  = 2 * WORD_W;
  localparam int OUT_FIELDS = DIST_W + 2 * COUNT_W;
  localparam int OUT_DATA_W = ((OUT_FIELDS + 7) / 8) * 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic acc_en;
    logic load_div;
    logic div_step;
    logic out_load;
  } tbd_cmd_t;

  typedef struct packed {
    logic div_last;
  } tbd_status_t;

endpackage

// ===== src/tbd_datapath.sv =====
module tbd_datapath
  import tbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  tbd_cmd_t              cmd,
  output tbd_status_t           status,
  input  logic [WORD_W-1:0]     word_a,
  input  logic [WORD_W-1:0]     word_b,
  output logic [DIST_W-1:0]     distance_q16,
  output logic [COUNT_W-1:0]    differing_bits,
  output logic [COUNT_W-1:0]    shared_bits
);

  function automatic logic [POP_W-1:0] pop32(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] v2;
    logic [WORD_W-1:0] v3;
    logic [WORD_W-1:0] v4;
    logic [WORD_W-1:0] v5;
    v1 = v - ((v >> 1) & 32'h5555_5555);
    v2 = (v1 & 32'h3333_3333) + ((v1 >> 2) & 32'h3333_3333);
    v3 = (v2 + (v2 >> 4)) & 32'h0F0F_0F0F;
    v4 = v3 + (v3 >> 8);
    v5 = v4 + (v4 >> 16);
    return v5[POP_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] acc,
                                                 input logic [POP_W-1:0] inc);
    logic [UNION_W-1:0] s;
    s = {1'b0, acc} + {{(UNION_W-POP_W){1'b0}}, inc};
    return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

  logic [COUNT_W-1:0] diff_total;
  logic [COUNT_W-1:0] shared_total;
  logic [COUNT_W-1:0] diff_next;
  logic [COUNT_W-1:0] shared_next;

  logic [COUNT_W-1:0] div_diff;
  logic [COUNT_W-1:0] div_shared;
  logic [UNION_W-1:0] divisor;
  logic [REM_W-1:0]   rem;
  logic [DIST_W-1:0]  quot;
  logic               union_zero;
  logic [STEP_W-1:0]  step_cnt;

  logic               ge;
  logic [REM_W-1:0]   rem_sub;

  assign diff_next   = sat_add(diff_total, pop32(word_a ^ word_b));
  assign shared_next = sat_add(shared_total, pop32(word_a & word_b));

  assign ge      = rem >= {1'b0, divisor};
  assign rem_sub = ge ? rem - {1'b0, divisor} : rem;

  assign status.div_last = step_cnt == STEP_W'(DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_total   <= '0;
      shared_total <= '0;
    end else if (cmd.acc_en) begin
      if (cmd.load_div) begin
        diff_total   <= '0;
        shared_total <= '0;
      end else begin
        diff_total   <= diff_next;
        shared_total <= shared_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      div_diff   <= diff_next;
      div_shared <= shared_next;
      divisor    <= {1'b0, diff_next} + {1'b0, shared_next};
      union_zero <= (diff_next == '0) && (shared_next == '0);
      rem        <= {{(REM_W-COUNT_W){1'b0}}, diff_next};
      quot       <= '0;
      step_cnt   <= '0;
    end else if (cmd.div_step) begin
      rem      <= {rem_sub[REM_W-2:0], 1'b0};
      quot     <= {quot[DIST_W-2:0], ge};
      step_cnt <= step_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      distance_q16   <= union_zero ? '0 : quot;
      differing_bits <= div_diff;
      shared_bits    <= div_shared;
    end
  end

endmodule

// ===== src/tbd_controller.sv =====
module tbd_controller
  import tbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tbd_status_t status,
  output tbd_cmd_t    cmd,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready
);

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;
  logic       out_free;

  assign in_ready = state == ST_ACC;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd.acc_en   = 1'b0;
    cmd.load_div = 1'b0;
    cmd.div_step = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      ST_ACC: begin
        cmd.acc_en   = accept;
        cmd.load_div = accept && in_last;
        if (accept && in_last) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.out_load = out_free;
        if (out_free) begin
          state_next = ST_ACC;
        end
      end
      default: begin
        state_next = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/tanimoto_bit_distance.sv =====
// Tanimoto distance between two binary fingerprints streamed as pairs of 32-bit
// words. Words are accepted one per cycle while the fingerprints accumulate; the
// differing and shared bit counts saturate at 4095. The word marked by tlast closes
// the pair, after which the input is held off while the restoring divider (one
// quotient bit per cycle) forms the Q1.16 distance and while the output register
// is loaded. A result waiting in the output register does not block the next
// fingerprint's words, but the load at the end of the next division waits for it,
// which stretches that hold-off by every cycle the earlier result stays unaccepted.
// An empty union gives distance 0.
module tanimoto_bit_distance
  import tbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // word_a [31:0], word_b [63:32]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // distance_q16 [16:0], differing_bits [28:17], shared_bits [40:29], zeros above
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  tbd_cmd_t           cmd;
  tbd_status_t        status;
  logic [DIST_W-1:0]  distance_q16;
  logic [COUNT_W-1:0] differing_bits;
  logic [COUNT_W-1:0] shared_bits;

  tbd_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .cmd       (cmd),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

  tbd_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .word_a         (s_axis_tdata[WORD_W-1:0]),
    .word_b         (s_axis_tdata[IN_DATA_W-1:WORD_W]),
    .distance_q16   (distance_q16),
    .differing_bits (differing_bits),
    .shared_bits    (shared_bits)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-OUT_FIELDS){1'b0}}, shared_bits, differing_bits,
                         distance_q16};

  a_last_holds_input: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken during division");

  a_distance_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[DIST_W-1:0] <= DIST_W'(1 << (DIST_W - 1)))
    else $error("distance above one");

  a_no_diff_zero_dist: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[DIST_W+COUNT_W-1:DIST_W] == '0)
      |-> m_axis_tdata[DIST_W-1:0] == '0)
    else $error("nonzero distance without differing bits");

  a_full_diff_is_one: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[DIST_W+COUNT_W-1:DIST_W] != '0)
      && (m_axis_tdata[OUT_FIELDS-1:DIST_W+COUNT_W] == '0)
      |-> m_axis_tdata[DIST_W-1:0] == DIST_W'(1 << (DIST_W - 1)))
    else $error("disjoint fingerprints not at distance one");

endmodule

// ===== verif/tb_tanimoto_bit_distance.sv =====
module tb_tanimoto_bit_distance;
  timeunit 1ns;
  timeprecision 1ps;

  import tbd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [COUNT_W-1:0] diff;
    logic [COUNT_W-1:0] common;
  } tanimoto_result_t;

  typedef enum int {
    PAT_RANDOM,
    PAT_SPARSE,
    PAT_DENSE,
    PAT_EQUAL,
    PAT_INVERSE,
    PAT_ZERO
  } word_pattern_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  tanimoto_result_t pending_results[$];
  tanimoto_result_t want;
  logic [COUNT_W-1:0] run_diff = '0;
  logic [COUNT_W-1:0] run_common = '0;
  logic               run_saturated = 1'b0;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int errors = 0;
  int cycles = 0;
  int words_sent = 0;
  int fingerprints_sent = 0;
  int results_checked = 0;
  int saturated_runs = 0;
  int drain_pauses = 0;

  tanimoto_bit_distance dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("tanimoto_bit_distance test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  function automatic logic [DIST_W-1:0] tanimoto_q16(input logic [COUNT_W-1:0] d,
                                                      input logic [COUNT_W-1:0] c);
    logic [UNION_W-1:0] u;
    logic [28:0]        num;
    u = UNION_W'(d) + UNION_W'(c);
    if (u == '0) return '0;
    num = {1'b0, d, 16'h0000};
    return DIST_W'(num / u);
  endfunction

  function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] acc,
                                                    input int inc);
    int sum;
    sum = int'(acc) + inc;
    return (sum > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(sum);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (m_axis_tdata[16:0] !== want.distance)
          report_mismatch($sformatf("distance_q16 got %0d exp %0d",
                                    m_axis_tdata[16:0], want.distance));
        if (m_axis_tdata[28:17] !== want.diff)
          report_mismatch($sformatf("differing_bits got %0d exp %0d",
                                    m_axis_tdata[28:17], want.diff));
        if (m_axis_tdata[40:29] !== want.common)
          report_mismatch($sformatf("shared_bits got %0d exp %0d",
                                    m_axis_tdata[40:29], want.common));
        if (m_axis_tdata[OUT_DATA_W-1:OUT_FIELDS] !== '0)
          report_mismatch($sformatf("padding bits got %h",
                                    m_axis_tdata[OUT_DATA_W-1:OUT_FIELDS]));
      end
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                           input logic is_last);
    tanimoto_result_t r;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tlast  <= is_last;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    if (int'(run_diff) + $countones(a ^ b) > int'(COUNT_MAX) ||
        int'(run_common) + $countones(a & b) > int'(COUNT_MAX))
      run_saturated = 1'b1;
    run_diff   = sat_count(run_diff, $countones(a ^ b));
    run_common = sat_count(run_common, $countones(a & b));
    if (is_last) begin
      r.distance = tanimoto_q16(run_diff, run_common);
      r.diff     = run_diff;
      r.common   = run_common;
      pending_results = {pending_results, r};
      fingerprints_sent++;
      if (run_saturated) saturated_runs++;
      run_diff      = '0;
      run_common    = '0;
      run_saturated = 1'b0;
    end
  endtask

  // hold the input off until every result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_fill(input int n, input logic [WORD_W-1:0] a,
                           input logic [WORD_W-1:0] b);
    for (int i = 0; i < n; i++) send_word(a, b, i == n - 1);
  endtask

  task automatic test_directed();
    send_word(32'h0000_0000, 32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    send_word(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_word(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    send_word(32'hFFFF_0000, 32'hFFFF_FFFF, 1'b1);
    send_word(32'h0000_0007, 32'h0000_0001, 1'b1);
    send_word(32'h8000_0000, 32'h8000_0001, 1'b1);
    send_word(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 32'h0000_0000, 1'b1);
    send_word(32'h1234_5678, 32'h8765_4321, 1'b0);
    send_word(32'hDEAD_BEEF, 32'hFEED_FACE, 1'b0);
    send_word(32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1);
    send_word(32'h0000_0001, 32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 32'h0000_0000, 1'b1);
  endtask

  task automatic test_saturation();
    send_fill(128, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_fill(127, 32'hFFFF_FFFF, 32'h0000_0000);
    for (int i = 0; i < 127; i++) send_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
    send_fill(130, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fill(258, 32'hFFFF_FFFF, 32'h0000_FFFF);
  endtask

  task automatic test_random(input int n_words);
    int            stop_at;
    int            len;
    word_pattern_t pat;
    logic [31:0]   a;
    logic [31:0]   b;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 49) == 0) len = $urandom_range(65, 160);
      else if ($urandom_range(0, 7) == 0) len = $urandom_range(7, 64);
      else len = $urandom_range(1, 6);
      pat = word_pattern_t'($urandom_range(0, 5));
      for (int i = 0; i < len; i++) begin
        a = $urandom();
        b = $urandom();
        case (pat)
          PAT_SPARSE:  begin a = a & $urandom(); b = b & $urandom(); end
          PAT_DENSE:   begin a = a | $urandom(); b = b | $urandom(); end
          PAT_EQUAL:   b = a;
          PAT_INVERSE: b = ~a;
          PAT_ZERO:    if ($urandom_range(0, 3) != 0) begin a = '0; b = '0; end
          default:     ;
        endcase
        send_word(a, b, i == len - 1);
      end
      if ($urandom_range(0, 29) == 0) begin
        wait_drained();
        drain_pauses++;
      end
    end
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 4; k++) begin
      send_word($urandom(), $urandom(), 1'b0);
      send_word($urandom(), $urandom(), 1'b1);
      wait_drained();
      drain_pauses++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct   = 38;
    sink_stall_pct = 54;
    test_directed();
    test_saturation();
    test_random(150);

    src_idle_pct   = 54;
    sink_stall_pct = 38;
    test_random(150);
    test_drain_pause();

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_random(146);
    test_drain_pause();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words in %0d fingerprints, %0d with saturated counts",
             words_sent, fingerprints_sent, saturated_runs);
    $display("checked %0d results, %0d drain pauses, %0d errors",
             results_checked, drain_pauses, errors);
    if (errors == 0) begin
      $display("tanimoto_bit_distance test passed");
    end else begin
      $display("tanimoto_bit_distance test failed");
    end
    $finish;
  end

endmodule
